[hdl/assert_macros.svh]
// Assertion macros used by the RTL of the audio jitter ring buffer.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AJRB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AJRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/ajrb_pkg.sv]
// Package for the audio jitter ring buffer: mode codes, register indexes,
// reset values and the status struct passed from the control unit to the top.
package ajrb_pkg;

	localparam int DEPTH_DEFAULT = 32768;

	localparam logic [15:0] START_LEVEL_RESET = 16'd2415;
	localparam logic [15:0] HIGH_WATER_RESET  = 16'd4485;

	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_PULL  = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic {
		CFG_START_LEVEL = 1'b0,
		CFG_HIGH_WATER  = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic        deliver;
		logic        overwrote;
		logic        above;
		logic [15:0] fill;
	} ajrb_status_t;

endpackage

[hdl/audio_jitter_ring_buffer.sv]
// Audio jitter ring buffer: an overwriting byte-sample FIFO over a DEPTH-entry RAM.
// Depends on ajrb_pkg, ajrb_ctrl, ajrb_ram and assert_macros.svh.
//
// Usage: each input beat carries a mode (push, pull or clear), a sample and a
// burst start flag, and produces exactly one output beat with the dequeued
// sample (zero when none), the fill after the operation, a high-water flag and
// an overwrite flag. Pushing into a full store discards the oldest sample.
// A pull marked as burst start only opens the burst if the fill has reached
// start_level; pulls on a closed burst or an empty store deliver nothing.
// The output beat is registered, and one beat is accepted every cycle while
// the output is not stalled: pointers and count update in the accepting cycle
// while the RAM read and the output register complete in the next one.
// When the receiver stalls, the single output register holds its beat and the
// input is refused until that beat is taken.
// The configuration channel writes start_level (index 0) or high_water_level
// (index 1) and is always ready. Reset empties the buffer, closes the burst
// and loads the default levels; the sample RAM is not cleared, as only counted
// entries are ever read.
`include "assert_macros.svh"

module audio_jitter_ring_buffer
	import ajrb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  sample_in,
	input  logic        burst_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  sample_out,
	output logic        sample_valid,
	output logic [15:0] fill_level,
	output logic        above_high_water,
	output logic        overwrote_oldest,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int PTR_W = $clog2(DEPTH);

	logic [15:0]      start_level_q, high_water_q;
	logic             in_fire;
	logic             wr_en;
	logic [PTR_W-1:0] wr_addr, rd_addr;
	logic [7:0]       rd_data;
	ajrb_status_t     status;
	logic             out_valid_q;
	ajrb_status_t     status_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_level_q <= START_LEVEL_RESET;
			high_water_q  <= HIGH_WATER_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_START_LEVEL: start_level_q <= cfg_data;
				CFG_HIGH_WATER:  high_water_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	ajrb_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (in_fire),
		.mode            (mode),
		.burst_start     (burst_start),
		.start_level     (start_level_q),
		.high_water_level(high_water_q),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.rd_addr         (rd_addr),
		.status          (status)
	);

	// The read data register only moves when a sample is dequeued, so it holds
	// through an output stall together with the result register.
	ajrb_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(sample_in),
		.rd_en  (in_fire && status.deliver),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			status_s1 <= status;
		end
	end

	assign out_valid        = out_valid_q;
	assign sample_valid     = status_s1.deliver;
	assign sample_out       = status_s1.deliver ? rd_data : 8'd0;
	assign fill_level       = status_s1.fill;
	assign above_high_water = status_s1.above;
	assign overwrote_oldest = status_s1.overwrote;

	`AJRB_ASSERT_NEXT(a_result_follows, clk, arst_n, in_fire, out_valid, "accepted beat gave no result")
	`AJRB_ASSERT_SAME(a_overwrite_push, clk, arst_n, in_fire && status.overwrote, mode == MODE_PUSH && !status.deliver, "overwrite outside a push")
	`AJRB_ASSERT_NEXT(a_clear_empties, clk, arst_n, in_fire && mode == MODE_CLEAR, fill_level == 16'd0 && !sample_valid, "clear left samples behind")

endmodule

[hdl/ajrb_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ajrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hdl/ajrb_ctrl.sv]
// Pointer, count and burst control of the audio jitter ring buffer.
// Depends on ajrb_pkg; drives the sample RAM addresses and the per-item status.
module ajrb_ctrl
	import ajrb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     fire,
	input  logic [1:0]               mode,
	input  logic                     burst_start,
	input  logic [15:0]              start_level,
	input  logic [15:0]              high_water_level,
	output logic                     wr_en,
	output logic [$clog2(DEPTH)-1:0] wr_addr,
	output logic [$clog2(DEPTH)-1:0] rd_addr,
	output ajrb_status_t             status
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q, rd_ptr_d, wr_ptr_d, rd_ptr_inc, wr_ptr_inc;
	logic [CNT_W-1:0] count_q, count_d;
	logic             burst_open_q, burst_open_d;
	logic             deliver, overwrote;

	assign rd_ptr_inc = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
	assign wr_ptr_inc = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;

	always_comb begin
		rd_ptr_d     = rd_ptr_q;
		wr_ptr_d     = wr_ptr_q;
		count_d      = count_q;
		burst_open_d = burst_open_q;
		deliver      = 1'b0;
		overwrote    = 1'b0;
		wr_en        = 1'b0;
		unique case (mode_t'(mode))
			MODE_PUSH: begin
				wr_en    = fire;
				wr_ptr_d = wr_ptr_inc;
				if (count_q == CNT_FULL) begin
					// Full store: the oldest sample is dropped in favour of the new one.
					rd_ptr_d  = rd_ptr_inc;
					overwrote = 1'b1;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			MODE_PULL: begin
				if (burst_start) begin
					burst_open_d = (CMP_W'(count_q) >= CMP_W'(start_level));
				end
				if (burst_open_d && count_q != '0) begin
					deliver  = 1'b1;
					rd_ptr_d = rd_ptr_inc;
					count_d  = count_q - 1'b1;
				end
			end
			MODE_CLEAR: begin
				rd_ptr_d = '0;
				wr_ptr_d = '0;
				count_d  = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q     <= '0;
			wr_ptr_q     <= '0;
			count_q      <= '0;
			burst_open_q <= 1'b0;
		end else if (fire) begin
			rd_ptr_q     <= rd_ptr_d;
			wr_ptr_q     <= wr_ptr_d;
			count_q      <= count_d;
			burst_open_q <= burst_open_d;
		end
	end

	assign wr_addr          = wr_ptr_q;
	assign rd_addr          = rd_ptr_q;
	assign status.deliver   = deliver;
	assign status.overwrote = overwrote;
	assign status.above     = (CMP_W'(count_d) > CMP_W'(high_water_level));
	assign status.fill      = 16'(count_d);

endmodule
